### src/cda_pkg.sv
package cda_pkg;

  // Datapath sizing
  localparam int YEAR_WIDTH = 16;
  localparam int ADD_WIDTH  = 16;

  // Leap-year cycle and its century marks
  localparam int LEAP_CYCLE = 400;
  localparam int CENTURY    = 100;
  localparam int REM_W      = 9;

  // Remainder unit: year mod 400 = ((year >> 4) mod 25) * 16 + year[3:0]
  localparam int LOW_W    = 4;
  localparam int MOD_BASE = LEAP_CYCLE >> LOW_W;
  localparam int MOD_W    = REM_W - LOW_W;
  localparam int HI_W     = YEAR_WIDTH - LOW_W;
  localparam int PROD_W   = 2 * HI_W;
  localparam int Q_W      = YEAR_WIDTH - 8;
  localparam int QX_W     = Q_W + MOD_W;
  // 2^YEAR_WIDTH / 25 rounded up; quotient is exact for every HI_W-bit value
  localparam longint unsigned RCP_FULL =
    ((64'd1 << YEAR_WIDTH) + 64'(MOD_BASE - 1)) / 64'(MOD_BASE);
  localparam logic [HI_W-1:0] RCP_25 = HI_W'(RCP_FULL);

  // Calendar codes
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_FIRST = 5'd1;

  typedef struct packed {
    logic [15:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [15:0] days_to_add;
  } in_req_t;

  typedef struct packed {
    logic [15:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic        bad_date;
    logic        year_wrapped;
  } out_rsp_t;

  // Working date; r400 tracks year mod 400
  typedef struct packed {
    logic [YEAR_WIDTH-1:0] year;
    logic [3:0]            month;
    logic [4:0]            day;
    logic [REM_W-1:0]      r400;
  } date_t;

  // Leap test from year mod 400 (year mod 4 is its low two bits)
  function automatic logic is_leap(input logic [REM_W-1:0] r400);
    logic by_cent;
    by_cent = (r400 == REM_W'(CENTURY)) || (r400 == REM_W'(2 * CENTURY)) ||
              (r400 == REM_W'(3 * CENTURY));
    return (r400 == '0) || ((r400[1:0] == 2'b00) && !by_cent);
  endfunction

  // Month length; zero for a month code outside January..December
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

### src/cda_rem400.sv
module cda_rem400 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cda_pkg::YEAR_WIDTH-1:0] year,
  output logic                          done,
  output logic [cda_pkg::REM_W-1:0]     rem
);
  import cda_pkg::*;

  logic                  mul_r;
  logic                  sub_r;
  logic                  done_r;
  logic [YEAR_WIDTH-1:0] year_r;
  logic [Q_W-1:0]        quo_r;
  logic [REM_W-1:0]      rem_r;
  logic [PROD_W-1:0]     prod;
  logic [QX_W-1:0]       quo_x25;
  logic [QX_W-1:0]       diff;

  // Upper bits divided by 25 through the reciprocal, then remainder by subtract
  always_comb begin
    prod    = PROD_W'(year_r[YEAR_WIDTH-1:LOW_W]) * PROD_W'(RCP_25);
    quo_x25 = QX_W'(quo_r) * QX_W'(MOD_BASE);
    diff    = QX_W'(year_r[YEAR_WIDTH-1:LOW_W]) - quo_x25;
  end

  // Three-step sequence: load, multiply, subtract
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= start;
      sub_r  <= mul_r;
      done_r <= sub_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (start) begin
      year_r <= year;
    end
    if (mul_r) begin
      quo_r <= prod[PROD_W-1:YEAR_WIDTH];
    end
    if (sub_r) begin
      rem_r <= {diff[MOD_W-1:0], year_r[LOW_W-1:0]};
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### src/cda_day_step.sv
module cda_day_step (
  input  cda_pkg::date_t cur,
  output cda_pkg::date_t nxt,
  output logic           wrap
);
  import cda_pkg::*;

  logic [4:0] len;
  logic       last_day;
  logic       last_month;
  logic       last_year;

  // Advance the date by one day
  always_comb begin
    len        = month_len(cur.month, is_leap(cur.r400));
    last_day   = (cur.day == len);
    last_month = (cur.month == MONTH_DEC);
    last_year  = &cur.year;
    nxt        = cur;
    wrap       = 1'b0;
    if (!last_day) begin
      nxt.day = cur.day + 5'd1;
    end else begin
      nxt.day = DAY_FIRST;
      if (!last_month) begin
        nxt.month = cur.month + 4'd1;
      end else begin
        nxt.month = MONTH_JAN;
        if (last_year) begin
          nxt.year = '0;
          nxt.r400 = '0;
          wrap     = 1'b1;
        end else begin
          nxt.year = cur.year + YEAR_WIDTH'(1);
          nxt.r400 = (cur.r400 == REM_W'(LEAP_CYCLE - 1)) ? '0 : cur.r400 + REM_W'(1);
        end
      end
    end
  end

endmodule

### src/calendar_date_add_days.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall   in_data   (start date, day count)
// out_     output     out_valid/out_stall out_data  (result date, flags)
//
// One request at a time. After acceptance, year mod 400 is formed by a
// reciprocal multiply and subtract, then the date moves one day per cycle
// for days_to_add days. A bad date skips the day loop.
// Reset (rst_n, synchronous) empties the output register and returns to idle.
// in_stall is high from acceptance until the result is loaded into the output
// register; a stalled result waits there.
module calendar_date_add_days (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cda_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cda_pkg::out_rsp_t out_data
);
  import cda_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REM,
    S_RUN,
    S_DONE
  } state_t;

  state_t                state_r;
  date_t                 date_r;
  logic [ADD_WIDTH-1:0]  cnt_r;
  logic                  wrap_r;
  logic                  bad_r;
  logic                  out_valid_r;
  out_rsp_t              out_data_r;

  logic                  accept;
  logic                  out_free;
  logic                  rem_done;
  logic [REM_W-1:0]      rem;
  logic [4:0]            chk_len;
  logic                  chk_bad;
  date_t                 step_date;
  logic                  step_wrap;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Year mod 400 for the leap rule
  cda_rem400 u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .year  (YEAR_WIDTH'(in_data.in_year)),
    .done  (rem_done),
    .rem   (rem)
  );

  // Next-day unit, used once per cycle in the day loop
  cda_day_step u_step (
    .cur  (date_r),
    .nxt  (step_date),
    .wrap (step_wrap)
  );

  // Start-date check
  always_comb begin
    chk_len = month_len(date_r.month, is_leap(rem));
    chk_bad = (chk_len == 5'd0) || (date_r.day == 5'd0) || (date_r.day > chk_len);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            date_r.year  <= YEAR_WIDTH'(in_data.in_year);
            date_r.month <= in_data.in_month;
            date_r.day   <= in_data.in_day;
            cnt_r        <= ADD_WIDTH'(in_data.days_to_add);
            wrap_r       <= 1'b0;
            state_r      <= S_REM;
          end
        end
        S_REM: begin
          if (rem_done) begin
            date_r.r400 <= rem;
            bad_r       <= chk_bad;
            state_r     <= chk_bad ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (cnt_r == '0) begin
            state_r <= S_DONE;
          end else begin
            date_r <= step_date;
            wrap_r <= wrap_r | step_wrap;
            cnt_r  <= cnt_r - ADD_WIDTH'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r.out_year     <= 16'(date_r.year);
            out_data_r.out_month    <= date_r.month;
            out_data_r.out_day      <= date_r.day;
            out_data_r.bad_date     <= bad_r;
            out_data_r.year_wrapped <= wrap_r;
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_run_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> date_r.day != 5'd0 &&
      date_r.day <= month_len(date_r.month, is_leap(date_r.r400)))
    else $error("day loop holds an invalid date");

  a_run_r400_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> date_r.r400 < REM_W'(LEAP_CYCLE) &&
      date_r.r400[1:0] == date_r.year[1:0])
    else $error("year mod 400 out of step with year");

  a_bad_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_date |-> !out_data.year_wrapped)
    else $error("bad date reported with year wrap");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_REM)
    else $error("accepted request did not start remainder step");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cda_pkg::*;

  // Queued request plus a flag that holds it back until all results are in
  typedef struct packed {
    logic    drain_first;
    in_req_t req;
  } pending_req_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_data;

  pending_req_t pending_q[$];
  out_rsp_t     date_due_q[$];
  int unsigned  req_sent = 0;
  int unsigned  req_taken = 0;
  int unsigned  gap_left = 0;
  int unsigned  stall_left = 0;
  int unsigned  mismatches = 0;

  calendar_date_add_days dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Gregorian leap rule; year 0 is a leap year
  function automatic bit leap_rule(input longint unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  // Zero for a month code outside January..December
  function automatic int unsigned days_of_month(input longint unsigned y,
                                                input int unsigned m);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      MONTH_FEB:             len = leap_rule(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // Date after the requested number of days, stepped one day at a time
  function automatic out_rsp_t advance_date(input in_req_t r);
    longint unsigned ymax, y, n;
    int unsigned     m, d, len;
    out_rsp_t        res;
    ymax = (64'd1 << YEAR_WIDTH) - 1;
    y    = r.in_year & ymax;
    m    = r.in_month;
    d    = r.in_day;
    n    = r.days_to_add & ((64'd1 << ADD_WIDTH) - 1);
    res  = '0;
    len  = days_of_month(y, m);
    if (len == 0 || d == 0 || d > len) begin
      // invalid date: echoed back untouched
      res.bad_date = 1'b1;
    end else begin
      while (n > 0) begin
        if (d == days_of_month(y, m)) begin
          d = DAY_FIRST;
          if (m == MONTH_DEC) begin
            m = MONTH_JAN;
            if (y == ymax) begin
              y = 0;
              res.year_wrapped = 1'b1;
            end else begin
              y++;
            end
          end else begin
            m++;
          end
        end else begin
          d++;
        end
        n--;
      end
    end
    res.out_year  = 16'(y);
    res.out_month = 4'(m);
    res.out_day   = 5'(d);
    return res;
  endfunction

  // Mostly short idle stretches, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    if (roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    return gap;
  endfunction

  task automatic add_req(input int unsigned y, input int unsigned m, input int unsigned d,
                         input int unsigned n, input bit drain);
    pending_req_t p;
    p.drain_first     = drain;
    p.req.in_year     = 16'(y);
    p.req.in_month    = 4'(m);
    p.req.in_day      = 5'(d);
    p.req.days_to_add = 16'(n);
    pending_q.push_back(p);
  endtask

  // Request driver: one request offered at a time, random gap after each
  always @(negedge clk) begin
    pending_req_t nxt;
    if (rst_n && !(in_valid && req_taken != req_sent)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q[0];
        if (!nxt.drain_first || date_due_q.size() == 0) begin
          in_data  <= nxt.req;
          in_valid <= 1'b1;
          void'(pending_q.pop_front());
          req_sent++;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left = pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on accepted requests, check each accepted result
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        date_due_q.push_back(advance_date(in_data));
        req_taken++;
      end
      if (out_valid && !out_stall) begin
        if (date_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: %0d-%0d-%0d bad %b wrap %b",
                     out_data.out_year, out_data.out_month, out_data.out_day,
                     out_data.bad_date, out_data.year_wrapped);
        end else begin
          want = date_due_q.pop_front();
          if (out_data.out_year != want.out_year || out_data.out_month != want.out_month ||
              out_data.out_day != want.out_day || out_data.bad_date != want.bad_date ||
              out_data.year_wrapped != want.year_wrapped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d-%0d-%0d bad %b wrap %b, got %0d-%0d-%0d bad %b wrap %b",
                       want.out_year, want.out_month, want.out_day, want.bad_date,
                       want.year_wrapped, out_data.out_year, out_data.out_month,
                       out_data.out_day, out_data.bad_date, out_data.year_wrapped);
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned y, m, d, n, roll, len;
    int          k;

    // Directed: zero days, leap rules, month and year ends, wrap, bad dates
    add_req(2024, 3, 15, 0, 1'b0);
    add_req(2024, MONTH_FEB, 28, 1, 1'b0);
    add_req(2023, MONTH_FEB, 28, 1, 1'b0);
    add_req(1900, MONTH_FEB, 28, 1, 1'b0);
    add_req(2000, MONTH_FEB, 28, 2, 1'b0);
    add_req(0, MONTH_FEB, 28, 1, 1'b0);
    add_req(2023, MONTH_DEC, 31, 1, 1'b0);
    add_req(2023, 4, 30, 1, 1'b0);
    add_req(2023, MONTH_JAN, 31, 31, 1'b0);
    add_req(65535, MONTH_DEC, 31, 1, 1'b0);
    add_req(65535, MONTH_DEC, 31, 0, 1'b0);
    add_req(65535, MONTH_DEC, DAY_FIRST, 65535, 1'b0);
    add_req(0, MONTH_JAN, DAY_FIRST, 65535, 1'b0);
    add_req(65535, 0, 0, 65535, 1'b0);
    add_req(2023, 13, 5, 10, 1'b0);
    add_req(2023, 15, 31, 10, 1'b0);
    add_req(2023, 4, 31, 1, 1'b0);
    add_req(2023, MONTH_FEB, 29, 1, 1'b0);
    add_req(2024, MONTH_FEB, 30, 0, 1'b0);
    add_req(2024, 6, 0, 5, 1'b0);

    // Random: mostly valid dates, some noise and dates one past month end
    for (k = 0; k < 80; k++) begin
      case ($urandom_range(0, 4))
        0:       y = $urandom_range(0, 655) * 100;
        1:       y = $urandom_range(65528, 65535);
        2:       y = $urandom_range(0, 16383) * 4;
        default: y = $urandom_range(0, 65535);
      endcase
      m   = $urandom_range(1, 12);
      len = days_of_month(y, m);
      case ($urandom_range(0, 3))
        0:       d = DAY_FIRST;
        1:       d = len;
        2:       d = len - 1;
        default: d = $urandom_range(1, len);
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        y = $urandom_range(0, 65535);
        m = $urandom_range(0, 15);
        d = $urandom_range(0, 31);
      end else if (roll < 20) begin
        d = len + 1;
      end
      // day count: a handful of long runs, the rest short
      roll = $urandom_range(0, 99);
      if (k % 25 == 20) n = $urandom_range(32768, 65535);
      else if (roll < 40) n = $urandom_range(0, 3);
      else if (roll < 85) n = $urandom_range(0, 400);
      else n = $urandom_range(0, 4095);
      add_req(y, m, d, n, k == 0 || k == 50);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || req_taken != req_sent || date_due_q.size() != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
